@@ rtl/det_pkg.sv @@
// ----------------------------------------------------------------------------
// det_pkg
// shared widths, command and status codes, scan control types
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int NAME_W  = 56;
  localparam int INODE_W = 32;
  localparam int CMD_W   = 2;
  localparam int STS_W   = 3;
  localparam int IDX_OUT_W = 6;
  localparam int HW_OUT_W  = 7;

  localparam logic [INODE_W-1:0] INODE_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEARCH = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_RSV    = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK         = 3'd0,
    STS_NOT_FOUND  = 3'd1,
    STS_DUPLICATE  = 3'd2,
    STS_FULL       = 3'd3,
    STS_EMPTY_NAME = 3'd4
  } status_t;

  // control from the sequencer to the scan tracker
  typedef struct packed {
    logic start;
    logic chk;
  } det_scan_ctl_t;

  // what the scan has found so far
  typedef struct packed {
    logic hit;
    logic free;
  } det_scan_flag_t;

endpackage

@@ rtl/det_if.sv @@
// ----------------------------------------------------------------------------
// det_if
// request and response channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface det_req_if;
  logic                        valid;
  logic                        ready;
  logic [det_pkg::CMD_W-1:0]   cmd;
  logic [det_pkg::NAME_W-1:0]  entry_name;
  logic [det_pkg::INODE_W-1:0] entry_inode;

  modport source (output valid, output cmd, output entry_name, output entry_inode,
                  input ready);
  modport sink   (input valid, input cmd, input entry_name, input entry_inode,
                  output ready);
endinterface

interface det_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [det_pkg::STS_W-1:0]     status;
  logic [det_pkg::INODE_W-1:0]   found_inode;
  logic [det_pkg::IDX_OUT_W-1:0] slot_index;
  logic [det_pkg::HW_OUT_W-1:0]  high_water;

  modport source (output valid, output status, output found_inode, output slot_index,
                  output high_water, input ready);
  modport sink   (input valid, input status, input found_inode, input slot_index,
                  input high_water, output ready);
endinterface

@@ rtl/det_scan.sv @@
// ----------------------------------------------------------------------------
// det_scan
// compares each slot word read back against the request key and keeps the
// first matching slot and the first free slot
// ----------------------------------------------------------------------------
module det_scan #(
  parameter int IDX_W = 6,
  parameter int KEY_W = 56
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  det_pkg::det_scan_ctl_t        ctl,
  input  logic [IDX_W-1:0]              chk_idx,
  input  logic [KEY_W-1:0]              rd_key,
  input  logic [det_pkg::INODE_W-1:0]   rd_inode,
  input  logic [KEY_W-1:0]              req_key,
  output det_pkg::det_scan_flag_t       flags,
  output logic [IDX_W-1:0]              hit_idx,
  output logic [det_pkg::INODE_W-1:0]   hit_inode,
  output logic [IDX_W-1:0]              free_idx
);
  import det_pkg::*;

  det_scan_flag_t     flags_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [INODE_W-1:0] hit_inode_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               slot_used;
  logic               hit_now;
  logic               free_now;

  // a slot is in use when its first name byte is non-zero
  assign slot_used = (rd_key[7:0] != 8'h00);
  assign hit_now   = ctl.chk && slot_used && (rd_key == req_key);
  assign free_now  = ctl.chk && !slot_used;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      flags_r <= '0;
    end else begin
      if (hit_now)  flags_r.hit  <= 1'b1;
      if (free_now) flags_r.free <= 1'b1;
    end
  end

  // lowest index wins: capture only on the first one seen
  always_ff @(posedge clk) begin
    if (hit_now && !flags_r.hit) begin
      hit_idx_r   <= chk_idx;
      hit_inode_r <= rd_inode;
    end
    if (free_now && !flags_r.free) begin
      free_idx_r <= chk_idx;
    end
  end

  assign flags     = flags_r;
  assign hit_idx   = hit_idx_r;
  assign hit_inode = hit_inode_r;
  assign free_idx  = free_idx_r;

endmodule

@@ rtl/directory_entry_table_core.sv @@
// ----------------------------------------------------------------------------
// directory_entry_table_core
// fixed table of directory slots: search, create in lowest free slot, delete
// ----------------------------------------------------------------------------
// a word with a non-empty name and a valid command is read against every slot
//   in S_SCAN, then passes S_WAIT and S_FINISH before its result is registered;
//   no new word is taken until the sequencer is back in S_IDLE
// the scan pace is set by the slot memory's single read port: one slot per cycle
// reserved command or empty name: no scan, straight from S_IDLE to S_FINISH
// reset: a clearing pass writes every slot after rst_n, no word taken meanwhile
// ----------------------------------------------------------------------------
module directory_entry_table_core #(
  parameter int SLOT_COUNT = 64,
  parameter int NAME_BYTES = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  det_req_if.sink   in_req,
  det_rsp_if.source out_rsp
);
  import det_pkg::*;

  // only the bytes that fit in the name field can ever be non-zero
  localparam int KEY_BYTES = (NAME_BYTES < NAME_W / 8) ? NAME_BYTES : NAME_W / 8;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int WORD_W    = KEY_W + INODE_W;
  localparam int IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int HWM_W     = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_FINISH
  } state_t;

  // keep the bytes before the first zero byte
  function automatic logic [KEY_W-1:0] pack_key(input logic [NAME_W-1:0] raw);
    logic [KEY_W-1:0] key;
    logic             keep;
    key  = '0;
    keep = 1'b1;
    for (int b = 0; b < KEY_BYTES; b++) begin
      keep = keep && (raw[8*b +: 8] != 8'h00);
      if (keep) key[8*b +: 8] = raw[8*b +: 8];
    end
    return key;
  endfunction

  // sequencer state
  state_t             state_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               chk_vld_r;
  logic [IDX_W-1:0]   chk_idx_r;

  // request held for the whole scan
  cmd_t               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [INODE_W-1:0] inode_r;

  // high-water count of used slots
  logic [HWM_W-1:0]   used_mark_r;
  logic [HWM_W-1:0]   used_mark_nxt;
  logic [HWM_W-1:0]   new_mark;

  // response register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [INODE_W-1:0] out_inode_r;
  logic [IDX_W-1:0]   out_idx_r;

  // slot memory: key in the low bits, inode above
  logic [WORD_W-1:0]  slot_mem [SLOT_COUNT];
  logic [WORD_W-1:0]  rd_word_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [WORD_W-1:0]  mem_wd;

  // scan tracker
  det_scan_ctl_t      scan_ctl;
  det_scan_flag_t     scan_flags;
  logic [IDX_W-1:0]   hit_idx;
  logic [INODE_W-1:0] hit_inode;
  logic [IDX_W-1:0]   free_idx;

  // finishing step
  logic               in_take;
  logic               in_bypass;
  logic               out_free;
  logic               fin_go;
  status_t            rsp_status;
  logic [INODE_W-1:0] rsp_inode;
  logic [IDX_W-1:0]   rsp_idx;
  logic               do_fill;
  logic               do_drop;
  logic [KEY_W-1:0]   in_key;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_take      = in_req.valid && in_req.ready;
  assign in_key       = pack_key(in_req.entry_name);
  // reserved command and empty name need no scan
  assign in_bypass    = (cmd_t'(in_req.cmd) == CMD_RSV) || (in_key[7:0] == 8'h00);

  assign out_free = !out_valid_r || out_rsp.ready;
  assign fin_go   = (state_r == S_FINISH) && out_free;

  assign scan_ctl.start = in_take;
  assign scan_ctl.chk   = chk_vld_r;

  det_scan #(
    .IDX_W (IDX_W),
    .KEY_W (KEY_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .chk_idx   (chk_idx_r),
    .rd_key    (rd_word_r[KEY_W-1:0]),
    .rd_inode  (rd_word_r[WORD_W-1:KEY_W]),
    .req_key   (key_r),
    .flags     (scan_flags),
    .hit_idx   (hit_idx),
    .hit_inode (hit_inode),
    .free_idx  (free_idx)
  );

  // decide the answer once the scan is complete
  always_comb begin
    rsp_status = STS_NOT_FOUND;
    rsp_inode  = '0;
    rsp_idx    = '0;
    do_fill    = 1'b0;
    do_drop    = 1'b0;
    if (cmd_r == CMD_RSV) begin
      rsp_status = STS_NOT_FOUND;
    end else if (key_r[7:0] == 8'h00) begin
      rsp_status = STS_EMPTY_NAME;
    end else begin
      case (cmd_r)
        CMD_SEARCH: begin
          if (scan_flags.hit) begin
            rsp_status = STS_OK;
            rsp_inode  = hit_inode;
            rsp_idx    = hit_idx;
          end
        end
        CMD_CREATE: begin
          if (scan_flags.hit) begin
            rsp_status = STS_DUPLICATE;
          end else if (scan_flags.free) begin
            rsp_status = STS_OK;
            rsp_idx    = free_idx;
            do_fill    = 1'b1;
          end else begin
            rsp_status = STS_FULL;
          end
        end
        CMD_DELETE: begin
          if (scan_flags.hit) begin
            rsp_status = STS_OK;
            rsp_inode  = hit_inode;
            rsp_idx    = hit_idx;
            do_drop    = 1'b1;
          end
        end
        default: begin
          rsp_status = STS_NOT_FOUND;
        end
      endcase
    end
  end

  // high water grows to one past the slot just filled
  assign new_mark      = HWM_W'(free_idx) + HWM_W'(1);
  assign used_mark_nxt = (do_fill && (new_mark > used_mark_r)) ? new_mark : used_mark_r;

  // write port: clearing pass, then fills and deletes
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_idx_r;
    mem_wd = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (fin_go && do_fill) begin
      mem_we = 1'b1;
      mem_wa = free_idx;
      mem_wd = {inode_r, key_r};
    end else if (fin_go && do_drop) begin
      mem_we = 1'b1;
      mem_wa = hit_idx;
      mem_wd = {INODE_NONE, KEY_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_wa] <= mem_wd;
    rd_word_r <= slot_mem[rd_idx_r];
  end

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      rd_idx_r    <= '0;
      chk_vld_r   <= 1'b0;
      used_mark_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chk_vld_r <= (state_r == S_SCAN);
      chk_idx_r <= rd_idx_r;
      // a new result loaded in the same cycle keeps valid high
      if (out_valid_r && out_rsp.ready && !fin_go) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (rd_idx_r == LAST_IDX) begin
            rd_idx_r <= '0;
            state_r  <= S_IDLE;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (in_take) begin
            cmd_r    <= cmd_t'(in_req.cmd);
            key_r    <= in_key;
            inode_r  <= in_req.entry_inode;
            rd_idx_r <= '0;
            state_r  <= in_bypass ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx_r == LAST_IDX) begin
            state_r <= S_WAIT;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        S_WAIT: begin
          // last slot word is compared in this cycle
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= rsp_status;
            out_inode_r  <= rsp_inode;
            out_idx_r    <= rsp_idx;
            used_mark_r  <= used_mark_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.found_inode = out_inode_r;
  assign out_rsp.slot_index  = IDX_OUT_W'(out_idx_r);
  assign out_rsp.high_water  = HW_OUT_W'(used_mark_r);

  // no write may land while slots are being read for a request
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_WAIT) |-> !mem_we)
    else $error("slot memory written during scan");

  // high-water count never falls
  a_mark_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (used_mark_r >= $past(used_mark_r)))
    else $error("high-water count decreased");

  // high-water count stays within the table
  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_mark_r <= HWM_W'(SLOT_COUNT))
    else $error("high-water count beyond slot count");

  // a fill only ever targets a slot the scan saw empty, never when the scan found a match
  a_fill_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && do_fill) |-> (scan_flags.free && !scan_flags.hit))
    else $error("create fill without a free slot or with a match");

endmodule
